FILE: design/uks_pkg.sv
// ----------------------------------------------------------------------------
// uks_pkg
// Shared codes and types for the unsorted key set: request opcodes, result
// status codes and the memory command bundle.
// ----------------------------------------------------------------------------
package uks_pkg;

  localparam int OP_WIDTH     = 2;
  localparam int KEY_PORT_W   = 32;
  localparam int STATUS_WIDTH = 2;
  localparam int LIVE_WIDTH   = 5;

  // request opcodes; the spare code behaves as a membership query
  localparam logic [OP_WIDTH-1:0] OP_QUERY  = 2'd0;
  localparam logic [OP_WIDTH-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_WIDTH-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_WIDTH-1:0] OP_SPARE  = 2'd3;

  // result status codes
  localparam logic [STATUS_WIDTH-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_DUP    = 2'd2;
  localparam logic [STATUS_WIDTH-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_cmd_t;

endpackage

FILE: design/unsorted_key_set_top.sv
// ----------------------------------------------------------------------------
// unsorted_key_set_top
// Set of distinct keys in an unsorted memory with a live count: membership
// query, insert with duplicate and full checks, and swap-with-last remove.
//
//   channel   handshake        payload
//   request   start / busy     op, key
//   result    done (strobe)    success, status, live_count
//
// A request scans the live entries one memory read at a time (at least one
// read), fetches the last entry on a remove hit, then gives the result; the
// scan is paced by the single memory read port. Reset clears the state and
// the count only; the key memory needs no clearing. Results cannot be
// stalled; done is high for one cycle.
// ----------------------------------------------------------------------------
module unsorted_key_set_top #(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [uks_pkg::OP_WIDTH-1:0]     op,
  input  logic [uks_pkg::KEY_PORT_W-1:0]   key,
  output logic                             done,
  output logic                             success,
  output logic [uks_pkg::STATUS_WIDTH-1:0] status,
  output logic [uks_pkg::LIVE_WIDTH-1:0]   live_count
);
  import uks_pkg::*;

  // only the low key bits take part
  localparam int MW = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
  localparam int AW = $clog2(CAPACITY);

  mem_cmd_t      mem_cmd;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [MW-1:0] wr_data;
  logic [MW-1:0] rd_data;

  uks_ctrl #(
    .CAPACITY (CAPACITY),
    .MW       (MW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .op         (op),
    .key        (key[MW-1:0]),
    .busy       (busy),
    .done       (done),
    .success    (success),
    .status     (status),
    .live_count (live_count),
    .mem_cmd    (mem_cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_data    (rd_data)
  );

  uks_store #(
    .DEPTH (CAPACITY),
    .DW    (MW)
  ) u_store (
    .clk     (clk),
    .cmd     (mem_cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

endmodule

FILE: design/uks_store.sv
// ----------------------------------------------------------------------------
// uks_store
// Key memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module uks_store #(
  parameter int DEPTH = 16,
  parameter int DW    = 32
) (
  input  logic                     clk,
  input  uks_pkg::mem_cmd_t        cmd,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data,
  output logic [DW-1:0]            rd_data
);
  import uks_pkg::*;

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/uks_ctrl.sv
// ----------------------------------------------------------------------------
// uks_ctrl
// Request sequencer: scans the live entries one memory read per cycle,
// then appends, swap-removes or just answers, and drives the result strobe.
// ----------------------------------------------------------------------------
module uks_ctrl #(
  parameter int CAPACITY = 16,
  parameter int MW       = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [uks_pkg::OP_WIDTH-1:0]     op,
  input  logic [MW-1:0]                    key,
  output logic                             busy,
  output logic                             done,
  output logic                             success,
  output logic [uks_pkg::STATUS_WIDTH-1:0] status,
  output logic [uks_pkg::LIVE_WIDTH-1:0]   live_count,
  output uks_pkg::mem_cmd_t                mem_cmd,
  output logic [$clog2(CAPACITY)-1:0]      rd_addr,
  output logic [$clog2(CAPACITY)-1:0]      wr_addr,
  output logic [MW-1:0]                    wr_data,
  input  logic [MW-1:0]                    rd_data
);
  import uks_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_LAST = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t                  state, state_next;
  logic [AW-1:0]           idx, idx_next;
  logic [AW-1:0]           slot, slot_next;
  logic [OP_WIDTH-1:0]     op_q, op_q_next;
  logic [MW-1:0]           key_q, key_q_next;
  logic [CW-1:0]           count, count_next;
  logic                    success_q, success_q_next;
  logic [STATUS_WIDTH-1:0] status_q, status_q_next;

  logic          hit;
  logic          more;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] last;

  assign idx_inc = CW'(idx) + CW'(1);
  assign last    = count - CW'(1);
  // data for idx arrives this cycle; only live entries are compared
  assign hit     = (count != '0) && (rd_data == key_q);
  assign more    = idx_inc < count;

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    slot_next      = slot;
    op_q_next      = op_q;
    key_q_next     = key_q;
    count_next     = count;
    success_q_next = success_q;
    status_q_next  = status_q;
    mem_cmd        = '0;
    rd_addr        = '0;
    wr_addr        = '0;
    wr_data        = key_q;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_q_next     = op;
          key_q_next    = key;
          idx_next      = '0;
          mem_cmd.rd_en = 1'b1;
          rd_addr       = '0;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (op_q == OP_REMOVE) begin
            // fetch the last live entry to fill the freed slot
            slot_next     = idx;
            mem_cmd.rd_en = 1'b1;
            rd_addr       = last[AW-1:0];
            state_next    = S_LAST;
          end else begin
            success_q_next = (op_q != OP_INSERT);
            status_q_next  = (op_q == OP_INSERT) ? ST_DUP : ST_OK;
            state_next     = S_RESP;
          end
        end else if (more) begin
          idx_next      = idx_inc[AW-1:0];
          mem_cmd.rd_en = 1'b1;
          rd_addr       = idx_inc[AW-1:0];
        end else begin
          success_q_next = 1'b0;
          status_q_next  = ST_ABSENT;
          if (op_q == OP_INSERT) begin
            if (count >= CAP_C) begin
              status_q_next = ST_FULL;
            end else begin
              mem_cmd.wr_en  = 1'b1;
              wr_addr        = count[AW-1:0];
              wr_data        = key_q;
              count_next     = count + CW'(1);
              success_q_next = 1'b1;
              status_q_next  = ST_OK;
            end
          end
          state_next = S_RESP;
        end
      end
      S_LAST: begin
        mem_cmd.wr_en  = 1'b1;
        wr_addr        = slot;
        wr_data        = rd_data;
        count_next     = last;
        success_q_next = 1'b1;
        status_q_next  = ST_OK;
        state_next     = S_RESP;
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    slot      <= slot_next;
    op_q      <= op_q_next;
    key_q     <= key_q_next;
    success_q <= success_q_next;
    status_q  <= status_q_next;
  end

  assign busy       = (state != S_IDLE);
  assign done       = (state == S_RESP);
  assign success    = success_q;
  assign status     = status_q;
  assign live_count = LIVE_WIDTH'(count);

`ifndef NO_ASSERTIONS
  a_done_single : assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

  a_count_range : assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C) else $error("live count beyond capacity");

  a_ok_success : assert property (@(posedge clk) disable iff (rst)
    done |-> (success == (status == ST_OK))) else $error("success and status disagree");

  a_no_write_and_scan : assert property (@(posedge clk) disable iff (rst)
    mem_cmd.wr_en |=> (state == S_RESP)) else $error("store written outside final step");

  a_count_step : assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> $stable(count)) else $error("count changed while idle");
`endif

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the unsorted key set. A short directed walk covers
// the empty store, duplicates, the spare opcode, swap-with-last and last-entry
// removes and the full store. A long random run then fills and drains the store
// over and over. Results are compared with the directed table or a local model.
// ----------------------------------------------------------------------------
module testbench;
  import uks_pkg::*;

  localparam int CAPACITY     = 16;
  localparam int RANDOM_ITEMS = 850;
  localparam int CALM_TAIL    = 100;   // last requests go out back to back
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic                    success;
    logic [STATUS_WIDTH-1:0] status;
    logic [LIVE_WIDTH-1:0]   live_count;
  } set_result_t;

  typedef struct {
    logic [OP_WIDTH-1:0]   op;
    logic [KEY_PORT_W-1:0] key;
    bit                    typed;
    set_result_t           res;
  } request_row_t;

  logic                    clk   = 1'b0;
  logic                    rst   = 1'b1;
  logic                    start = 1'b0;
  logic [OP_WIDTH-1:0]     op    = OP_QUERY;
  logic [KEY_PORT_W-1:0]   key   = '0;
  logic                    busy;
  logic                    done;
  logic                    success;
  logic [STATUS_WIDTH-1:0] status;
  logic [LIVE_WIDTH-1:0]   live_count;

  // model of the set and the results still owed by the block
  logic [KEY_PORT_W-1:0] held_keys [CAPACITY];
  int unsigned           held_count = 0;
  bit                    filling    = 1'b1;
  set_result_t           owed_results [$];
  request_row_t          directed_rows [$];
  int                    mismatches = 0;
  int                    results_seen = 0;

  unsorted_key_set_top #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_PORT_W)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .key        (key),
    .done       (done),
    .success    (success),
    .status     (status),
    .live_count (live_count)
  );

  always #5 clk = ~clk;

  function automatic int find_held(logic [KEY_PORT_W-1:0] k);
    for (int i = 0; i < held_count; i++) begin
      if (held_keys[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic set_result_t apply_request(logic [OP_WIDTH-1:0] rq_op,
                                                logic [KEY_PORT_W-1:0] rq_key);
    set_result_t r;
    int          slot;
    slot      = find_held(rq_key);
    r.success = 1'b0;
    r.status  = ST_ABSENT;
    case (rq_op)
      OP_INSERT: begin
        if (slot >= 0) begin
          r.status = ST_DUP;
        end else if (held_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          held_keys[held_count] = rq_key;
          held_count++;
          r.success = 1'b1;
          r.status  = ST_OK;
        end
      end
      OP_REMOVE: begin
        if (slot >= 0) begin
          // last live entry fills the hole
          held_keys[slot] = held_keys[held_count - 1];
          held_count--;
          r.success = 1'b1;
          r.status  = ST_OK;
        end
      end
      default: begin
        if (slot >= 0) begin
          r.success = 1'b1;
          r.status  = ST_OK;
        end
      end
    endcase
    r.live_count = LIVE_WIDTH'(held_count);
    return r;
  endfunction

  function automatic void add_row(logic [OP_WIDTH-1:0] r_op, logic [KEY_PORT_W-1:0] r_key,
                                  bit r_typed, logic r_succ,
                                  logic [STATUS_WIDTH-1:0] r_stat, int r_live);
    request_row_t row;
    row.op                 = r_op;
    row.key                = r_key;
    row.typed              = r_typed;
    row.res.success        = r_succ;
    row.res.status         = r_stat;
    row.res.live_count     = LIVE_WIDTH'(r_live);
    directed_rows.push_back(row);
  endfunction

  function automatic void build_directed_rows();
    add_row(OP_QUERY,  32'h0000_0000, 1, 1'b0, ST_ABSENT, 0);
    add_row(OP_REMOVE, 32'h0000_0005, 1, 1'b0, ST_ABSENT, 0);
    add_row(OP_INSERT, 32'h0000_0000, 1, 1'b1, ST_OK,     1);
    add_row(OP_INSERT, 32'h0000_0000, 1, 1'b0, ST_DUP,    1);
    add_row(OP_INSERT, 32'hFFFF_FFFF, 1, 1'b1, ST_OK,     2);
    add_row(OP_SPARE,  32'hFFFF_FFFF, 1, 1'b1, ST_OK,     2);
    add_row(OP_SPARE,  32'h1234_5678, 1, 1'b0, ST_ABSENT, 2);
    add_row(OP_REMOVE, 32'h0000_0000, 0, 1'b0, ST_OK,     0);
    for (int i = 0; i < CAPACITY - 1; i++) begin
      add_row(OP_INSERT, {28'hAAAA_AAA, 4'(i)}, 1, 1'b1, ST_OK, i + 2);
    end
    add_row(OP_INSERT, 32'h5555_5555, 1, 1'b0, ST_FULL,   CAPACITY);
    // duplicate wins over full
    add_row(OP_INSERT, 32'hAAAA_AAA3, 1, 1'b0, ST_DUP,    CAPACITY);
    add_row(OP_REMOVE, 32'hAAAA_AAAE, 1, 1'b1, ST_OK,     CAPACITY - 1);
  endfunction

  task automatic pick_random(output logic [OP_WIDTH-1:0] nop,
                             output logic [KEY_PORT_W-1:0] nkey);
    int r;
    if (held_count == CAPACITY) filling = 1'b0;
    else if (held_count == 0) filling = 1'b1;
    else if ($urandom_range(0, 39) == 0) filling = !filling;
    r = $urandom_range(0, 99);
    if (r < 6) nop = OP_SPARE;
    else if (r < 22) nop = OP_QUERY;
    else if (r < (filling ? 70 : 40)) nop = OP_INSERT;
    else nop = OP_REMOVE;
    // held keys for most non-insert requests, else fresh keys or a narrow pool
    r = $urandom_range(0, 99);
    if (held_count > 0 && r < ((nop == OP_INSERT) ? 15 : 70))
      nkey = held_keys[$urandom_range(0, held_count - 1)];
    else if (r < 85) nkey = $urandom();
    else nkey = KEY_PORT_W'($urandom_range(0, 31));
  endtask

  task automatic flag_mismatch(string what, logic [KEY_PORT_W-1:0] want_v,
                               logic [KEY_PORT_W-1:0] got_v);
    if (mismatches < 10)
      $display("result %0d: %s expected %0d, got %0d", results_seen, what, want_v, got_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    set_result_t want;
    if (!rst && done === 1'b1) begin
      if (owed_results.size() == 0) begin
        flag_mismatch("unexpected transaction, live_count", '0, live_count);
      end else begin
        want = owed_results.pop_front();
        if (success !== want.success) flag_mismatch("success", want.success, success);
        if (status !== want.status) flag_mismatch("status", want.status, status);
        if (live_count !== want.live_count)
          flag_mismatch("live_count", want.live_count, live_count);
      end
      results_seen++;
    end
  end

  initial begin
    set_result_t           predicted;
    logic [OP_WIDTH-1:0]   next_op;
    logic [KEY_PORT_W-1:0] next_key;
    int                    sent;
    int                    total;
    int                    gap;
    bit                    holding;
    bit                    idle_on;
    build_directed_rows();
    total   = directed_rows.size() + RANDOM_ITEMS;
    sent    = 0;
    gap     = 0;
    holding = 1'b0;
    idle_on = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (sent < total) begin
      @(posedge clk);
      if (start && !busy) begin
        predicted = apply_request(op, key);
        if (sent < directed_rows.size() && directed_rows[sent].typed)
          owed_results.push_back(directed_rows[sent].res);
        else
          owed_results.push_back(predicted);
        sent++;
        holding = 1'b0;
        if ($urandom_range(0, 29) == 0) idle_on = !idle_on;
      end
      if (!holding) begin
        if (gap > 0) begin
          gap--;
          start <= 1'b0;
        end else if (sent >= total) begin
          start <= 1'b0;
        end else if (idle_on && sent < total - CALM_TAIL && $urandom_range(0, 3) == 0) begin
          gap = $urandom_range(0, 11);
          start <= 1'b0;
        end else begin
          if (sent < directed_rows.size()) begin
            next_op  = directed_rows[sent].op;
            next_key = directed_rows[sent].key;
          end else begin
            pick_random(next_op, next_key);
          end
          start   <= 1'b1;
          op      <= next_op;
          key     <= next_key;
          holding = 1'b1;
        end
      end
    end
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: unsorted_key_set_top.f
design/uks_pkg.sv
design/uks_store.sv
design/uks_ctrl.sv
design/unsorted_key_set_top.sv
tb/sv/testbench.sv
